>>> rtl/positional_list_store_defines.svh
// ---------------------------------------------------------------------------
// Positional list store: assertion macros
// Shared property wrappers, clocked on clk; PLS_ASSERT is gated by arst_n.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// checked only while out of reset
`define PLS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PLS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pls_pkg.sv
// ---------------------------------------------------------------------------
// pls_pkg
// Types, sizes and codes shared by the positional list store.
// ---------------------------------------------------------------------------
package pls_pkg;

	localparam int CAPACITY   = 64;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int POS_W      = 7;
	localparam int OUT_CNT_W  = 7;
	localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

	// opcodes
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_DELETE  = 2'd1;
	localparam logic [1:0] OP_GET     = 2'd2;
	localparam logic [1:0] OP_REPLACE = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_BADPOS = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	// what a cell does this cycle
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_DELETE = 2'd2;
	localparam logic [1:0] CELL_WRITE  = 2'd3;

	typedef struct packed {
		logic [31:0] passenger;
		logic [7:0]  prio;
	} entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic [1:0]       kind;
		logic             rd;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} cell_ctl_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [7:0]  priority_in;
		logic [31:0] passenger_in;
		logic [6:0]  position;
		logic [1:0]  opcode;
	} in_item_t;

	typedef struct packed {
		logic [3:0]           pad;
		logic                 past_end;
		logic                 is_full;
		logic                 is_empty;
		logic [OUT_CNT_W-1:0] entry_count;
		logic [7:0]           priority_out;
		logic [31:0]          passenger_out;
		logic [1:0]           status;
	} out_item_t;

endpackage

>>> rtl/positional_list_store.sv
// ---------------------------------------------------------------------------
// positional_list_store
// Ordered list of passenger entries with insert, delete, get and replace
// at a 1-based position, kept in a row of shifting cells.
// ---------------------------------------------------------------------------
//  channel  | dir | width | contents (low bit first)
//  s_axis   | in  | 56    | opcode, position, passenger_in, priority_in
//  m_axis   | out | 56    | status, passenger_out, priority_out,
//           |     |       | entry_count, is_empty, is_full, past_end
//
//  An item is accepted in S_IDLE: the accept edge shifts or writes every cell at
//  once and captures the first level of the read OR tree. In S_GATHER the tree
//  is finished and loaded into the output register once that register is free.
//  A new item is taken once the previous one has reached the output
//  register, even while that result still waits on m_axis_tready.
//  Reset clears the entry count and the handshake state; cell contents are
//  not reset and are only read at positions below the count.
// ---------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // opcode, position, passenger_in, priority_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // status, passenger_out, priority_out,
	                                   // entry_count, is_empty, is_full, past_end
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_GATHER = 1'b1;

	typedef struct packed {
		logic [1:0]                   status;
		logic [pls_pkg::OUT_CNT_W-1:0] entry_count;
		logic                         is_empty;
		logic                         is_full;
		logic                         past_end;
	} meta_t;

	logic                          state_q;
	logic [pls_pkg::CNT_W-1:0]     count_q;
	logic [pls_pkg::CNT_W-1:0]     count_nxt;
	meta_t                         meta_s1;
	meta_t                         meta_d;
	logic                          out_valid_q;
	pls_pkg::out_item_t            out_q;

	pls_pkg::in_item_t             in_item;
	logic                          accept;
	logic                          out_free;
	logic [pls_pkg::CMP_W-1:0]     pos_ext;
	logic [pls_pkg::CMP_W-1:0]     cnt_ext;
	logic                          list_full;
	logic                          list_empty;
	logic [1:0]                    status_d;
	pls_pkg::cell_ctl_t            ctl;
	logic                          out_full_st;
	logic                          out_empty_st;

	pls_pkg::entry_t               cell_data [pls_pkg::CAPACITY];
	pls_pkg::entry_t [pls_pkg::PAD_DEPTH-1:0] rd_lanes;
	pls_pkg::entry_t               group_or [pls_pkg::NUM_GROUPS];
	pls_pkg::entry_t               rd_final;

	assign in_item  = s_axis_tdata;
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;

	// status decode on the incoming item
	assign pos_ext    = pls_pkg::CMP_W'(in_item.position);
	assign cnt_ext    = pls_pkg::CMP_W'(count_q);
	assign list_full  = (count_q == pls_pkg::CNT_W'(pls_pkg::CAPACITY));
	assign list_empty = (count_q == '0);

	always_comb begin
		status_d = pls_pkg::STAT_OK;
		if (in_item.opcode == pls_pkg::OP_INSERT) begin
			if (list_full) begin
				status_d = pls_pkg::STAT_FULL;
			end else if (pos_ext == '0 || pos_ext > cnt_ext + pls_pkg::CMP_W'(1)) begin
				status_d = pls_pkg::STAT_BADPOS;
			end
		end else begin
			if (list_empty) begin
				status_d = pls_pkg::STAT_EMPTY;
			end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
				status_d = pls_pkg::STAT_BADPOS;
			end
		end
	end

	// cell broadcast and count update
	always_comb begin
		ctl.kind  = pls_pkg::CELL_HOLD;
		ctl.rd    = 1'b0;
		ctl.idx   = pls_pkg::IDX_W'(pos_ext - pls_pkg::CMP_W'(1));
		ctl.data  = '{passenger: in_item.passenger_in, prio: in_item.priority_in};
		count_nxt = count_q;
		if (accept && status_d == pls_pkg::STAT_OK) begin
			unique case (in_item.opcode)
				pls_pkg::OP_INSERT: begin
					ctl.kind  = pls_pkg::CELL_INSERT;
					count_nxt = count_q + pls_pkg::CNT_W'(1);
				end
				pls_pkg::OP_DELETE: begin
					ctl.kind  = pls_pkg::CELL_DELETE;
					count_nxt = count_q - pls_pkg::CNT_W'(1);
				end
				pls_pkg::OP_GET: begin
					ctl.rd = 1'b1;
				end
				pls_pkg::OP_REPLACE: begin
					ctl.kind = pls_pkg::CELL_WRITE;
				end
				default: begin
					ctl.kind = pls_pkg::CELL_HOLD;
				end
			endcase
		end
	end

	// flags use the count after the operation
	always_comb begin
		meta_d.status      = status_d;
		meta_d.entry_count = pls_pkg::OUT_CNT_W'(count_nxt);
		meta_d.is_empty    = (count_nxt == '0);
		meta_d.is_full     = (count_nxt == pls_pkg::CNT_W'(pls_pkg::CAPACITY));
		meta_d.past_end    = (pos_ext != '0) && (pos_ext > pls_pkg::CMP_W'(count_nxt));
	end

	// the row of cells; ends see zero
	for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
		pls_pkg::entry_t prev_d;
		pls_pkg::entry_t next_d;
		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == pls_pkg::CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		pls_cell u_cell (
			.clk       (clk),
			.my_index  (pls_pkg::IDX_W'(i)),
			.ctl       (ctl),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i]),
			.rd_data   (rd_lanes[i])
		);
	end

	for (genvar i = pls_pkg::CAPACITY; i < pls_pkg::PAD_DEPTH; i++) begin : g_pad
		assign rd_lanes[i] = '0;
	end

	// first level of the read tree, captured on accept
	for (genvar g = 0; g < pls_pkg::NUM_GROUPS; g++) begin : g_grp
		pls_reduce u_reduce (
			.clk      (clk),
			.load     (accept),
			.lanes    (rd_lanes[g*pls_pkg::GROUP_SIZE +: pls_pkg::GROUP_SIZE]),
			.group_or (group_or[g])
		);
	end

	always_comb begin
		rd_final = '0;
		for (int g = 0; g < pls_pkg::NUM_GROUPS; g++) begin
			rd_final = rd_final | group_or[g];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_GATHER;
					end
				end
				S_GATHER: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_GATHER && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GATHER && out_free) begin
			out_q.pad           <= '0;
			out_q.past_end      <= meta_s1.past_end;
			out_q.is_full       <= meta_s1.is_full;
			out_q.is_empty      <= meta_s1.is_empty;
			out_q.entry_count   <= meta_s1.entry_count;
			out_q.priority_out  <= rd_final.prio;
			out_q.passenger_out <= rd_final.passenger;
			out_q.status        <= meta_s1.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign out_full_st  = out_valid_q && out_q.status == pls_pkg::STAT_FULL;
	assign out_empty_st = out_valid_q && out_q.status == pls_pkg::STAT_EMPTY;

	`PLS_ASSERT(a_count_bound, count_q <= pls_pkg::CNT_W'(pls_pkg::CAPACITY), "count over cap")
	`PLS_ASSERT(a_count_moves_on_accept, !$stable(count_q) |-> $past(accept), "count moved idle")
	`PLS_ASSERT(a_accept_to_gather, accept |=> state_q == S_GATHER, "accepted item not gathered")
	`PLS_ASSERT(a_full_flag, out_full_st |-> out_q.is_full, "full status without full flag")
	`PLS_ASSERT(a_empty_flag, out_empty_st |-> out_q.is_empty, "empty status without empty flag")
	`PLS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid && s_axis_tready, "reset not idle")

endmodule

>>> rtl/pls_cell.sv
// ---------------------------------------------------------------------------
// pls_cell
// One list slot: takes its left or right neighbor on insert or delete.
// ---------------------------------------------------------------------------
module pls_cell (
	input  logic                     clk,
	input  logic [pls_pkg::IDX_W-1:0] my_index,
	input  pls_pkg::cell_ctl_t       ctl,
	input  pls_pkg::entry_t          prev_data,
	input  pls_pkg::entry_t          next_data,
	output pls_pkg::entry_t          data,
	output pls_pkg::entry_t          rd_data
);

	pls_pkg::entry_t data_q;
	pls_pkg::entry_t data_nxt;
	logic            is_eq;
	logic            is_gt;

	assign is_eq = (my_index == ctl.idx);
	assign is_gt = (my_index > ctl.idx);

	always_comb begin
		data_nxt = data_q;
		unique case (ctl.kind)
			pls_pkg::CELL_INSERT: begin
				if (is_gt) begin
					data_nxt = prev_data;
				end else if (is_eq) begin
					data_nxt = ctl.data;
				end
			end
			pls_pkg::CELL_DELETE: begin
				if (is_gt || is_eq) begin
					data_nxt = next_data;
				end
			end
			pls_pkg::CELL_WRITE: begin
				if (is_eq) begin
					data_nxt = ctl.data;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data    = data_q;
	assign rd_data = (ctl.rd && is_eq) ? data_q : '0;

endmodule

>>> rtl/pls_reduce.sv
// ---------------------------------------------------------------------------
// pls_reduce
// Registered OR of one group of masked cell reads.
// ---------------------------------------------------------------------------
module pls_reduce (
	input  logic                                  clk,
	input  logic                                  load,
	input  pls_pkg::entry_t [pls_pkg::GROUP_SIZE-1:0] lanes,
	output pls_pkg::entry_t                       group_or
);

	pls_pkg::entry_t or_q;
	pls_pkg::entry_t or_d;

	always_comb begin
		or_d = '0;
		for (int i = 0; i < pls_pkg::GROUP_SIZE; i++) begin
			or_d = or_d | lanes[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			or_q <= or_d;
		end
	end

	assign group_or = or_q;

endmodule

>>> tb/pls_list_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pls_list_checker
// Watches both stream channels of the positional list store, keeps its own
// copy of the list, works out the reply to each accepted item and compares
// every returned reply field by field, oldest expectation first.
// ---------------------------------------------------------------------------
module pls_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [55:0] in_data,   // opcode, position, passenger_in, priority_in
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [55:0] out_data,  // status, passenger_out, priority_out,
	                               // entry_count, is_empty, is_full, past_end
	output int          mismatches,
	output int          pending,
	output int          results_checked
);

	typedef struct packed {
		logic [31:0] passenger;
		logic [7:0]  rank;
	} slot_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [7:0]  rank;
		logic [31:0] passenger;
		logic [6:0]  position;
		logic [1:0]  opcode;
	} list_op_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic        past_end;
		logic        is_full;
		logic        is_empty;
		logic [6:0]  entry_count;
		logic [7:0]  rank;
		logic [31:0] passenger;
		logic [1:0]  status;
	} list_reply_t;

	slot_t       slots [pls_pkg::CAPACITY];
	int          fill;
	list_reply_t replies_due [$];
	list_reply_t got;
	list_reply_t want;

	// one list operation against the local copy; returns the reply it gives
	function automatic list_reply_t apply_list_op(input list_op_t op);
		list_reply_t r;
		int p;
		r = '0;
		p = int'(op.position);
		r.status = pls_pkg::STAT_OK;
		if (op.opcode == pls_pkg::OP_INSERT) begin
			if (fill >= pls_pkg::CAPACITY) begin
				r.status = pls_pkg::STAT_FULL;
			end else if (p < 1 || p > fill + 1) begin
				r.status = pls_pkg::STAT_BADPOS;
			end else begin
				for (int i = fill; i > p - 1; i--)
					slots[i] = slots[i - 1];
				slots[p - 1].passenger = op.passenger;
				slots[p - 1].rank      = op.rank;
				fill++;
			end
		end else if (fill == 0) begin
			r.status = pls_pkg::STAT_EMPTY;
		end else if (p < 1 || p > fill) begin
			r.status = pls_pkg::STAT_BADPOS;
		end else if (op.opcode == pls_pkg::OP_DELETE) begin
			for (int i = p - 1; i + 1 < fill; i++)
				slots[i] = slots[i + 1];
			fill--;
		end else if (op.opcode == pls_pkg::OP_GET) begin
			r.passenger = slots[p - 1].passenger;
			r.rank      = slots[p - 1].rank;
		end else begin
			slots[p - 1].passenger = op.passenger;
			slots[p - 1].rank      = op.rank;
		end
		r.entry_count = 7'(fill);
		r.is_empty    = (fill == 0);
		r.is_full     = (fill == pls_pkg::CAPACITY);
		r.past_end    = (p >= 1) && (p - 1 >= fill);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
			mismatches++;
		end
	endtask

	// a reply never leaves on the edge that accepts its item, so pop before push
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			replies_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (replies_due.size() == 0) begin
					$display("%0t: reply %h with none expected", $time, out_data);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					results_checked++;
					check_field("status",        32'(want.status),      32'(got.status));
					check_field("passenger_out", want.passenger,        got.passenger);
					check_field("priority_out",  32'(want.rank),        32'(got.rank));
					check_field("entry_count",   32'(want.entry_count), 32'(got.entry_count));
					check_field("is_empty",      32'(want.is_empty),    32'(got.is_empty));
					check_field("is_full",       32'(want.is_full),     32'(got.is_full));
					check_field("past_end",      32'(want.past_end),    32'(got.past_end));
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(apply_list_op(list_op_t'(in_data)));
			pending <= replies_due.size();
		end
	end

endmodule

>>> tb/tb_positional_list_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_positional_list_store
// Drives list operations into the positional list store: a directed run
// over empty, bad-position and shifting cases, then phases that fill the
// list to capacity, churn it and drain it, with random gaps and stalls.
// A separate checker predicts and compares every reply.
// ---------------------------------------------------------------------------
module tb_positional_list_store;

	localparam int STALL_LIMIT = 500;  // cycles with no handshake at all
	localparam int PHASE_ITEMS = 115;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;  // opcode, position, passenger_in, priority_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // status, passenger_out, priority_out,
	                                  // entry_count, is_empty, is_full, past_end

	int mismatches;
	int pending;
	int results_checked;

	// stimulus-side bookkeeping: only the entry count, used to aim positions
	int fill_shadow;
	int peak_fill;
	int full_hits;
	int empty_hits;
	int badpos_hits;
	int items_sent;

	bit tx_eager;     // sender: no gaps in this phase
	bit rx_eager = 1'b0;  // receiver: no stalls in this phase
	int rx_hold;
	int rx_draw;
	int idle_cycles;

	always #5 clk = ~clk;

	positional_list_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pls_list_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_data         (s_axis_tdata),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_data        (m_axis_tdata),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// Receiver: after each accepted reply, draw a random hold and keep tready low until it runs out.
	// Ready may sit high with nothing valid; that is legal on the bus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (m_axis_tready && m_axis_tvalid) begin
			rx_draw = rx_eager ? 0 : int'($urandom_range(0, 8));
			m_axis_tready <= (rx_draw == 0);
			rx_hold <= rx_draw;
		end else if (!m_axis_tready) begin
			if (rx_hold <= 1) begin
				m_axis_tready <= 1'b1;
				rx_hold <= 0;
			end else begin
				rx_hold <= rx_hold - 1;
			end
		end
	end

	// Watchdog: a correct run never goes this long without a handshake
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d replies outstanding",
				$time, STALL_LIMIT, pending);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item after a random gap and wait for it to be taken.
	// With no gap, tvalid simply stays high into the next item.
	task automatic offer_item(input logic [1:0] op, input logic [6:0] pos,
			input logic [31:0] pid, input logic [7:0] rank);
		int gap;
		gap = tx_eager ? 0 : int'($urandom_range(0, 8));
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, rank, pid, pos, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		// track the count so later positions can be aimed inside the list
		if (op == pls_pkg::OP_INSERT) begin
			if (fill_shadow >= pls_pkg::CAPACITY)
				full_hits++;
			else if (pos >= 1 && pos <= fill_shadow + 1)
				fill_shadow++;
			else
				badpos_hits++;
		end else if (fill_shadow == 0) begin
			empty_hits++;
		end else if (pos < 1 || pos > fill_shadow) begin
			badpos_hits++;
		end else if (op == pls_pkg::OP_DELETE) begin
			fill_shadow--;
		end
		if (fill_shadow > peak_fill)
			peak_fill = fill_shadow;
	endtask

	// Mostly well-formed positions; one item in ten takes any 7-bit position
	// so that zero, just-past-end and far-out values all show up.
	task automatic run_phase(input int ins_pct, input int del_pct, input int n);
		int roll;
		int top;
		logic [1:0] op;
		logic [6:0] pos;
		for (int k = 0; k < n; k++) begin
			roll = int'($urandom_range(0, 99));
			if (roll < ins_pct)
				op = pls_pkg::OP_INSERT;
			else if (roll < ins_pct + del_pct)
				op = pls_pkg::OP_DELETE;
			else
				op = $urandom_range(0, 1) ? pls_pkg::OP_GET : pls_pkg::OP_REPLACE;
			if (op == pls_pkg::OP_INSERT)
				top = (fill_shadow < pls_pkg::CAPACITY) ? fill_shadow + 1 : pls_pkg::CAPACITY;
			else
				top = (fill_shadow > 0) ? fill_shadow : 1;
			if ($urandom_range(0, 99) < 10)
				pos = 7'($urandom_range(0, 127));
			else
				pos = 7'($urandom_range(1, top));
			offer_item(op, pos, $urandom(), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		tx_eager = 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty list: every non-insert op is refused, even at position zero
		offer_item(pls_pkg::OP_GET,     7'd1,   32'h0000_0001, 8'h01);
		offer_item(pls_pkg::OP_DELETE,  7'd1,   32'h0000_0002, 8'h02);
		offer_item(pls_pkg::OP_REPLACE, 7'd0,   32'h0000_0003, 8'h03);
		// insert at position zero and one past count+1
		offer_item(pls_pkg::OP_INSERT,  7'd0,   32'hDEAD_BEEF, 8'h11);
		offer_item(pls_pkg::OP_INSERT,  7'd2,   32'hDEAD_BEEF, 8'h22);
		// build a three-entry list: all ones, then zeros in front, then append
		offer_item(pls_pkg::OP_INSERT,  7'd1,   32'hFFFF_FFFF, 8'hFF);
		offer_item(pls_pkg::OP_INSERT,  7'd1,   32'h0000_0000, 8'h00);
		offer_item(pls_pkg::OP_INSERT,  7'd3,   32'hA5A5_A5A5, 8'h5A);
		offer_item(pls_pkg::OP_INSERT,  7'd5,   32'h1111_1111, 8'h44);
		// reads across the list, just past its end and far past it
		offer_item(pls_pkg::OP_GET,     7'd1,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd2,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd3,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd4,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd127, 32'h0,         8'h0);
		// overwrite in place, read back
		offer_item(pls_pkg::OP_REPLACE, 7'd2,   32'h1234_5678, 8'h80);
		offer_item(pls_pkg::OP_REPLACE, 7'd4,   32'h8765_4321, 8'h7F);
		offer_item(pls_pkg::OP_GET,     7'd2,   32'h0,         8'h0);
		// delete from the middle, a bad delete, then empty it out
		offer_item(pls_pkg::OP_DELETE,  7'd2,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_DELETE,  7'd0,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd2,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_DELETE,  7'd2,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_DELETE,  7'd1,   32'h0,         8'h0);
		offer_item(pls_pkg::OP_GET,     7'd1,   32'h0,         8'h0);

		// random phases: fill to capacity (hitting the full case), churn,
		// drain to empty (hitting the empty case), mixed; some phases burst
		for (int p = 0; p < 12; p++) begin
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager <= ($urandom_range(0, 3) == 0);
			case (p % 4)
				0: begin
					run_phase(80, 5, PHASE_ITEMS);
				end
				1: begin
					run_phase(40, 40, PHASE_ITEMS);
				end
				2: begin
					run_phase(5, 80, PHASE_ITEMS);
				end
				default: begin
					run_phase(55, 30, PHASE_ITEMS);
				end
			endcase
		end

		s_axis_tvalid <= 1'b0;
		rx_eager <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// room for any stray reply to show up
		repeat (12) @(posedge clk);

		$display("Sent %0d items, checked %0d replies; list reached %0d of %0d entries.",
			items_sent, results_checked, peak_fill, pls_pkg::CAPACITY);
		$display("Refusals seen: %0d full inserts, %0d on empty list, %0d bad positions.",
			full_hits, empty_hits, badpos_hits);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
